// ===== sv/frqf_pkg.sv =====
`default_nettype none

package frqf_pkg;

   // width of every statistics field on the result channel
   localparam int OUT_W = 48;
   // quality offset register width
   localparam int QOFS_W = 7;

   // quality thresholds, applied to quality minus offset
   localparam int LOW_QUAL_LIMIT = 10;
   localparam int Q20_LIMIT      = 20;

   // base letters
   localparam logic [7:0] CHAR_G_UP = 8'h47;
   localparam logic [7:0] CHAR_C_UP = 8'h43;
   localparam logic [7:0] CHAR_G_LO = 8'h67;
   localparam logic [7:0] CHAR_C_LO = 8'h63;
   localparam logic [7:0] CHAR_N_UP = 8'h4E;
   localparam logic [7:0] CHAR_N_LO = 8'h6E;

   // running totals, in result order
   localparam int TOT_RAW_READS   = 0;
   localparam int TOT_RAW_BASES   = 1;
   localparam int TOT_RAW_GC      = 2;
   localparam int TOT_RAW_Q20     = 3;
   localparam int TOT_CLEAN_READS = 4;
   localparam int TOT_CLEAN_BASES = 5;
   localparam int TOT_CLEAN_GC    = 6;
   localparam int TOT_CLEAN_Q20   = 7;
   localparam int NUM_TOTALS      = 8;

   typedef enum logic [1:0] {
      REASON_KEEP     = 2'd0,
      REASON_LOW_QUAL = 2'd1,
      REASON_MANY_N   = 2'd2,
      REASON_ADAPTER  = 2'd3
   } reject_reason_type;

   typedef enum logic {
      CSR_QUALITY_OFFSET = 1'b0,
      CSR_PAIRED_MODE    = 1'b1
   } csr_index_type;

   // read close control, top level to merge stage
   typedef struct packed {
      logic close;
      logic paired;
      logic adapter;
   } rd_ctl_type;

endpackage

`default_nettype wire

// ===== sv/frqf_lane.sv =====
`default_nettype none

// One mate: classifies each base and keeps the per-read counts.
module frqf_lane #(
   parameter int LEN_W = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [7:0]                    base,
   input  logic [7:0]                    qual,
   input  logic [frqf_pkg::QOFS_W-1:0]   quality_offset,
   input  logic                          count_en,
   input  logic                          accept,
   input  logic                          close,
   output logic [LEN_W-1:0]              gc_next,
   output logic [LEN_W-1:0]              n_next,
   output logic [LEN_W-1:0]              low_next,
   output logic [LEN_W-1:0]              q20_next
);
   import frqf_pkg::*;

   logic [8:0]       low_lim;
   logic [8:0]       q20_lim;
   logic             is_gc;
   logic             is_n;
   logic             is_low;
   logic             is_q20;
   logic [LEN_W-1:0] gc_ff;
   logic [LEN_W-1:0] n_ff;
   logic [LEN_W-1:0] low_ff;
   logic [LEN_W-1:0] q20_ff;

   // quality compares against offset-shifted limits; a quality below the
   // offset falls under the low limit
   assign low_lim = {2'b00, quality_offset} + 9'(LOW_QUAL_LIMIT);
   assign q20_lim = {2'b00, quality_offset} + 9'(Q20_LIMIT);
   assign is_low  = ({1'b0, qual} <= low_lim);
   assign is_q20  = ({1'b0, qual} >= q20_lim);

   // base letter classes
   assign is_gc = (base == CHAR_G_UP) || (base == CHAR_C_UP) ||
                  (base == CHAR_G_LO) || (base == CHAR_C_LO);
   assign is_n  = (base == CHAR_N_UP) || (base == CHAR_N_LO);

   // counts including this base
   assign gc_next  = gc_ff  + LEN_W'(count_en & is_gc);
   assign n_next   = n_ff   + LEN_W'(count_en & is_n);
   assign low_next = low_ff + LEN_W'(count_en & is_low);
   assign q20_next = q20_ff + LEN_W'(count_en & is_q20);

   // per-read counters, cleared when the read closes
   always_ff @(posedge clock) begin
      if (reset) begin
         gc_ff  <= '0;
         n_ff   <= '0;
         low_ff <= '0;
         q20_ff <= '0;
      end else if (accept) begin
         if (close) begin
            gc_ff  <= '0;
            n_ff   <= '0;
            low_ff <= '0;
            q20_ff <= '0;
         end else begin
            gc_ff  <= gc_next;
            n_ff   <= n_next;
            low_ff <= low_next;
            q20_ff <= q20_next;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/frqf_merge.sv =====
`default_nettype none

// Merges both lanes' counts at read close: snapshot, decision, totals.
module frqf_merge #(
   parameter int LEN_W = 11,
   parameter int TW    = 48
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  frqf_pkg::rd_ctl_type                          ctl,
   output logic                                          in_ready,
   input  logic [LEN_W-1:0]                              len,
   input  logic [LEN_W-1:0]                              gc1,
   input  logic [LEN_W-1:0]                              gc2,
   input  logic [LEN_W-1:0]                              n1,
   input  logic [LEN_W-1:0]                              n2,
   input  logic [LEN_W-1:0]                              low1,
   input  logic [LEN_W-1:0]                              low2,
   input  logic [LEN_W-1:0]                              q201,
   input  logic [LEN_W-1:0]                              q202,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic                                          keep,
   output frqf_pkg::reject_reason_type                   reason,
   output logic [frqf_pkg::NUM_TOTALS-1:0][frqf_pkg::OUT_W-1:0] tot_out
);
   import frqf_pkg::*;

   localparam int CW = LEN_W + 5;
   localparam int AW = LEN_W + 1;

   // snapshot stage
   logic             s1_valid_ff;
   logic             s1_paired_ff;
   logic             s1_adapter_ff;
   logic [LEN_W-1:0] s1_len_ff;
   logic [LEN_W-1:0] s1_gc1_ff;
   logic [LEN_W-1:0] s1_gc2_ff;
   logic [LEN_W-1:0] s1_n1_ff;
   logic [LEN_W-1:0] s1_n2_ff;
   logic [LEN_W-1:0] s1_low1_ff;
   logic [LEN_W-1:0] s1_low2_ff;
   logic [LEN_W-1:0] s1_q201_ff;
   logic [LEN_W-1:0] s1_q202_ff;

   // decision stage
   logic              s2_valid_ff;
   reject_reason_type s2_reason_ff;
   logic [AW-1:0]     s2_reads_ff;
   logic [AW-1:0]     s2_bases_ff;
   logic [AW-1:0]     s2_gc_ff;
   logic [AW-1:0]     s2_q20_ff;

   // result register and totals
   logic                    rsp_valid_ff;
   logic                    keep_ff;
   reject_reason_type       reason_ff;
   logic [TW-1:0]           tot_ff [NUM_TOTALS];
   logic [TW-1:0]           tot_in [NUM_TOTALS];
   logic [AW-1:0]           add_vec [NUM_TOTALS];
   logic [TW:0]             sum_vec [NUM_TOTALS];
   logic [TW+OUT_W-1:0]     tot_ext [NUM_TOTALS];

   logic              out_free;
   logic              s2_free;
   logic              s1_free;
   logic [CW-1:0]     len_x3;
   logic [CW-1:0]     len_w;
   logic              low_pair;
   logic              low_single;
   logic              n_pair;
   logic              n_single;
   logic              low_hit;
   logic              n_hit;
   reject_reason_type reason_in;

   // stall chain, output side back to input side
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign in_ready = s1_free;

   // snapshot of a closed read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= ctl.close;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && ctl.close) begin
         s1_paired_ff  <= ctl.paired;
         s1_adapter_ff <= ctl.adapter;
         s1_len_ff     <= len;
         s1_gc1_ff     <= gc1;
         s1_gc2_ff     <= gc2;
         s1_n1_ff      <= n1;
         s1_n2_ff      <= n2;
         s1_low1_ff    <= low1;
         s1_low2_ff    <= low2;
         s1_q201_ff    <= q201;
         s1_q202_ff    <= q202;
      end
   end

   // filter rules; single mode low >= len/3 is the same as 3*low + 2 >= len
   assign len_w      = CW'(s1_len_ff);
   assign len_x3     = len_w * CW'(3);
   assign low_pair   = (CW'(s1_low1_ff) * CW'(10) >= len_x3) ||
                       (CW'(s1_low2_ff) * CW'(10) >= len_x3);
   assign low_single = (CW'(s1_low1_ff) * CW'(3) + CW'(2) >= len_w);
   assign n_single   = (CW'(s1_n1_ff) * CW'(20) > len_w);
   assign n_pair     = n_single || (CW'(s1_n2_ff) * CW'(20) > len_w);
   assign low_hit    = s1_paired_ff ? low_pair : low_single;
   assign n_hit      = s1_paired_ff ? n_pair : n_single;

   // priority: low quality, then N, then adapter
   always_comb begin
      if (low_hit) begin
         reason_in = REASON_LOW_QUAL;
      end else if (n_hit) begin
         reason_in = REASON_MANY_N;
      end else if (s1_adapter_ff) begin
         reason_in = REASON_ADAPTER;
      end else begin
         reason_in = REASON_KEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // per-read increments; mate 2 only counts in paired mode
   always_ff @(posedge clock) begin
      if (s2_free && s1_valid_ff) begin
         s2_reason_ff <= reason_in;
         s2_reads_ff  <= s1_paired_ff ? AW'(2) : AW'(1);
         s2_bases_ff  <= s1_paired_ff ? {s1_len_ff, 1'b0} : {1'b0, s1_len_ff};
         s2_gc_ff     <= {1'b0, s1_gc1_ff} +
                         (s1_paired_ff ? {1'b0, s1_gc2_ff} : AW'(0));
         s2_q20_ff    <= {1'b0, s1_q201_ff} +
                         (s1_paired_ff ? {1'b0, s1_q202_ff} : AW'(0));
      end
   end

   // saturating accumulate; clean totals only for kept reads
   always_comb begin
      add_vec[TOT_RAW_READS]   = s2_reads_ff;
      add_vec[TOT_RAW_BASES]   = s2_bases_ff;
      add_vec[TOT_RAW_GC]      = s2_gc_ff;
      add_vec[TOT_RAW_Q20]     = s2_q20_ff;
      add_vec[TOT_CLEAN_READS] = (s2_reason_ff == REASON_KEEP) ? s2_reads_ff : '0;
      add_vec[TOT_CLEAN_BASES] = (s2_reason_ff == REASON_KEEP) ? s2_bases_ff : '0;
      add_vec[TOT_CLEAN_GC]    = (s2_reason_ff == REASON_KEEP) ? s2_gc_ff : '0;
      add_vec[TOT_CLEAN_Q20]   = (s2_reason_ff == REASON_KEEP) ? s2_q20_ff : '0;
      for (int k = 0; k < NUM_TOTALS; k++) begin
         sum_vec[k] = {1'b0, tot_ff[k]} + (TW + 1)'(add_vec[k]);
         tot_in[k]  = sum_vec[k][TW] ? '1 : sum_vec[k][TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_TOTALS; k++) begin
            tot_ff[k] <= '0;
         end
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
         if (s2_valid_ff) begin
            for (int k = 0; k < NUM_TOTALS; k++) begin
               tot_ff[k] <= tot_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_valid_ff) begin
         keep_ff   <= (s2_reason_ff == REASON_KEEP);
         reason_ff <= s2_reason_ff;
      end
   end

   // outputs; totals shown as their low result-width bits
   assign rsp_valid = rsp_valid_ff;
   assign keep      = keep_ff;
   assign reason    = reason_ff;

   always_comb begin
      for (int k = 0; k < NUM_TOTALS; k++) begin
         tot_ext[k] = {OUT_W'(0), tot_ff[k]};
         tot_out[k] = tot_ext[k][OUT_W-1:0];
      end
   end

   // keep flag agrees with the reason code
   a_keep_reason : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (keep_ff == (reason_ff == REASON_KEEP)))
      else $error("keep flag disagrees with reject reason");

   // clean reads never exceed raw reads
   a_clean_le_raw : assert property (@(posedge clock) disable iff (reset)
      tot_ff[TOT_CLEAN_READS] <= tot_ff[TOT_RAW_READS])
      else $error("clean read total above raw read total");

   // raw base total never goes down outside reset
   a_bases_mono : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> tot_ff[TOT_RAW_BASES] >= $past(tot_ff[TOT_RAW_BASES]))
      else $error("raw base total decreased");

   // a decided read waits while the result register is blocked
   a_s2_hold : assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_free) |=> (s2_valid_ff && $stable(s2_reason_ff)))
      else $error("decision stage lost a read under stall");

endmodule

`default_nettype wire

// ===== sv/fastq_read_quality_filter.sv =====
// A read's result passes the snapshot, decision and result registers in turn
// after its last base transfer. Throughput: one base position per cycle
// while req_ready is high; both mates are counted in two lanes side by side,
// and a read of any length closes without a gap.
// The saturating totals update once per read in a single accumulate stage.
// Reset (synchronous, active high) clears per-read counts, totals and valids,
// and sets quality offset to 33 and paired mode on.
`default_nettype none

module fastq_read_quality_filter #(
   parameter int MAX_READ_LEN = 1024,
   parameter int TOTAL_WIDTH  = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_we,
   input  logic [0:0]                        csr_index,
   input  logic [frqf_pkg::QOFS_W-1:0]       csr_wdata,
   // base stream
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_base_mate1,
   input  logic [7:0]                        req_qual_mate1,
   input  logic [7:0]                        req_base_mate2,
   input  logic [7:0]                        req_qual_mate2,
   input  logic                              req_last_of_read,
   input  logic                              req_adapter_listed,
   // per-read results
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_keep_read,
   output logic [1:0]                        rsp_reject_reason,
   output logic [frqf_pkg::OUT_W-1:0]        rsp_raw_read_total,
   output logic [frqf_pkg::OUT_W-1:0]        rsp_raw_base_total,
   output logic [frqf_pkg::OUT_W-1:0]        rsp_raw_gc_total,
   output logic [frqf_pkg::OUT_W-1:0]        rsp_raw_q20_total,
   output logic [frqf_pkg::OUT_W-1:0]        rsp_clean_read_total,
   output logic [frqf_pkg::OUT_W-1:0]        rsp_clean_base_total,
   output logic [frqf_pkg::OUT_W-1:0]        rsp_clean_gc_total,
   output logic [frqf_pkg::OUT_W-1:0]        rsp_clean_q20_total
);
   import frqf_pkg::*;

   localparam int LEN_W = $clog2(MAX_READ_LEN + 1);

   logic [QOFS_W-1:0] quality_offset_ff;
   logic              paired_mode_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  len_in;
   logic              accept;
   logic              count_en;
   rd_ctl_type        ctl;
   logic              merge_ready;
   reject_reason_type reason;

   logic [LEN_W-1:0] gc1, gc2, n1, n2, low1, low2, q201, q202;
   logic [NUM_TOTALS-1:0][OUT_W-1:0] tot_out;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         quality_offset_ff <= QOFS_W'(33);
         paired_mode_ff    <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_QUALITY_OFFSET: quality_offset_ff <= csr_wdata;
            CSR_PAIRED_MODE:    paired_mode_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_ready = merge_ready;
   assign accept    = req_valid && req_ready;

   // read length; positions past the limit are not counted
   assign count_en = (len_ff < LEN_W'(MAX_READ_LEN));
   assign len_in   = len_ff + LEN_W'(count_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (accept) begin
         len_ff <= req_last_of_read ? '0 : len_in;
      end
   end

   assign ctl.close   = accept && req_last_of_read;
   assign ctl.paired  = paired_mode_ff;
   assign ctl.adapter = req_adapter_listed;

   frqf_lane #(.LEN_W(LEN_W)) u_lane1 (
      .clock          (clock),
      .reset          (reset),
      .base           (req_base_mate1),
      .qual           (req_qual_mate1),
      .quality_offset (quality_offset_ff),
      .count_en       (count_en),
      .accept         (accept),
      .close          (req_last_of_read),
      .gc_next        (gc1),
      .n_next         (n1),
      .low_next       (low1),
      .q20_next       (q201)
   );

   frqf_lane #(.LEN_W(LEN_W)) u_lane2 (
      .clock          (clock),
      .reset          (reset),
      .base           (req_base_mate2),
      .qual           (req_qual_mate2),
      .quality_offset (quality_offset_ff),
      .count_en       (count_en),
      .accept         (accept),
      .close          (req_last_of_read),
      .gc_next        (gc2),
      .n_next         (n2),
      .low_next       (low2),
      .q20_next       (q202)
   );

   frqf_merge #(.LEN_W(LEN_W), .TW(TOTAL_WIDTH)) u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .in_ready  (merge_ready),
      .len       (len_in),
      .gc1       (gc1),
      .gc2       (gc2),
      .n1        (n1),
      .n2        (n2),
      .low1      (low1),
      .low2      (low2),
      .q201      (q201),
      .q202      (q202),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .keep      (rsp_keep_read),
      .reason    (reason),
      .tot_out   (tot_out)
   );

   assign rsp_reject_reason    = reason;
   assign rsp_raw_read_total   = tot_out[TOT_RAW_READS];
   assign rsp_raw_base_total   = tot_out[TOT_RAW_BASES];
   assign rsp_raw_gc_total     = tot_out[TOT_RAW_GC];
   assign rsp_raw_q20_total    = tot_out[TOT_RAW_Q20];
   assign rsp_clean_read_total = tot_out[TOT_CLEAN_READS];
   assign rsp_clean_base_total = tot_out[TOT_CLEAN_BASES];
   assign rsp_clean_gc_total   = tot_out[TOT_CLEAN_GC];
   assign rsp_clean_q20_total  = tot_out[TOT_CLEAN_Q20];

endmodule

`default_nettype wire

// ===== dv/fastq_read_quality_filter_tb.sv =====
`timescale 1ns / 1ps

module fastq_read_quality_filter_tb;
   import frqf_pkg::*;

   localparam int READ_CAP = 1024;
   localparam bit [63:0] TOTAL_MAX = 64'h0000_FFFF_FFFF_FFFF;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int LONG_HOLD_AFTER = 2;
   localparam int PHASE_POSITIONS = 20;
   localparam int NUM_PHASES = 8;

   typedef struct packed {
      logic [7:0] base1;
      logic [7:0] qual1;
      logic [7:0] base2;
      logic [7:0] qual2;
      logic       last;
      logic       adapter;
   } base_position_type;

   typedef struct packed {
      logic                             keep;
      reject_reason_type                reason;
      logic [NUM_TOTALS-1:0][OUT_W-1:0] totals;
   } read_outcome_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   // block ports
   logic              csr_we = 1'b0;
   logic [0:0]        csr_index = CSR_QUALITY_OFFSET;
   logic [QOFS_W-1:0] csr_wdata = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_base_mate1 = '0;
   logic [7:0]        req_qual_mate1 = '0;
   logic [7:0]        req_base_mate2 = '0;
   logic [7:0]        req_qual_mate2 = '0;
   logic              req_last_of_read = 1'b0;
   logic              req_adapter_listed = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_keep_read;
   logic [1:0]        rsp_reject_reason;
   logic [OUT_W-1:0]  rsp_raw_read_total;
   logic [OUT_W-1:0]  rsp_raw_base_total;
   logic [OUT_W-1:0]  rsp_raw_gc_total;
   logic [OUT_W-1:0]  rsp_raw_q20_total;
   logic [OUT_W-1:0]  rsp_clean_read_total;
   logic [OUT_W-1:0]  rsp_clean_base_total;
   logic [OUT_W-1:0]  rsp_clean_gc_total;
   logic [OUT_W-1:0]  rsp_clean_q20_total;

   fastq_read_quality_filter uut (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_base_mate1       (req_base_mate1),
      .req_qual_mate1       (req_qual_mate1),
      .req_base_mate2       (req_base_mate2),
      .req_qual_mate2       (req_qual_mate2),
      .req_last_of_read     (req_last_of_read),
      .req_adapter_listed   (req_adapter_listed),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_keep_read        (rsp_keep_read),
      .rsp_reject_reason    (rsp_reject_reason),
      .rsp_raw_read_total   (rsp_raw_read_total),
      .rsp_raw_base_total   (rsp_raw_base_total),
      .rsp_raw_gc_total     (rsp_raw_gc_total),
      .rsp_raw_q20_total    (rsp_raw_q20_total),
      .rsp_clean_read_total (rsp_clean_read_total),
      .rsp_clean_base_total (rsp_clean_base_total),
      .rsp_clean_gc_total   (rsp_clean_gc_total),
      .rsp_clean_q20_total  (rsp_clean_q20_total)
   );

   // shadow configuration and per-read tallies
   logic [QOFS_W-1:0] offset_cfg = 7'd33;
   bit                paired_cfg = 1'b1;
   int                bases_in_read = 0;
   int                gc_in_mate [2] = '{0, 0};
   int                q20_in_mate [2] = '{0, 0};
   int                low_in_mate [2] = '{0, 0};
   int                n_in_mate [2] = '{0, 0};
   bit [63:0]         stat_total [NUM_TOTALS] = '{default: 0};

   base_position_type position_q [$];
   read_outcome_type  read_outcomes [$];
   base_position_type offered;

   int  mismatches = 0;
   int  reads_checked = 0;
   int  send_gap = 0;
   int  send_calm = 0;
   bit  send_free;
   int  recv_stall = 0;
   int  recv_calm = 0;
   bit  long_hold_done = 1'b0;
   int  cycle_count = 0;

   string total_label [NUM_TOTALS] = '{"raw_read_total", "raw_base_total", "raw_gc_total",
      "raw_q20_total", "clean_read_total", "clean_base_total", "clean_gc_total",
      "clean_q20_total"};
   // quality above offset for the 30 percent boundary read: exactly three low
   int boundary_qual [10] = '{10, 10, 10, 11, 19, 20, 222, 11, 30, 40};

   function automatic bit [63:0] sat_sum(bit [63:0] cur, bit [63:0] add);
      if (cur > TOTAL_MAX)
         cur = TOTAL_MAX;
      if (add > TOTAL_MAX - cur)
         return TOTAL_MAX;
      return cur + add;
   endfunction

   // per-mate letter and quality tallies for one base position
   function automatic void tally_mate(int m, logic [7:0] b, logic [7:0] q);
      int diff;
      int off;
      diff = int'(q);
      off = int'(offset_cfg);
      diff = diff - off;
      if (b == CHAR_G_UP || b == CHAR_C_UP || b == CHAR_G_LO || b == CHAR_C_LO)
         gc_in_mate[m]++;
      else if (b == CHAR_N_UP || b == CHAR_N_LO)
         n_in_mate[m]++;
      if (diff <= LOW_QUAL_LIMIT)
         low_in_mate[m]++;
      if (diff >= Q20_LIMIT)
         q20_in_mate[m]++;
   endfunction

   // advance the read tallies by one transfer; at the last base, decide and total up
   function automatic void score_position(base_position_type p);
      reject_reason_type why;
      bit [63:0]         len;
      bit [63:0]         mates;
      bit [63:0]         add [NUM_TOTALS];
      read_outcome_type  o;
      if (bases_in_read < READ_CAP) begin
         bases_in_read++;
         tally_mate(0, p.base1, p.qual1);
         tally_mate(1, p.base2, p.qual2);
      end
      if (p.last) begin
         len = 64'(bases_in_read);
         mates = paired_cfg ? 64'd2 : 64'd1;
         if (paired_cfg) begin
            if (64'(low_in_mate[0]) * 64'd10 >= len * 64'd3 ||
                64'(low_in_mate[1]) * 64'd10 >= len * 64'd3)
               why = REASON_LOW_QUAL;
            else if (64'(n_in_mate[0]) * 64'd20 > len || 64'(n_in_mate[1]) * 64'd20 > len)
               why = REASON_MANY_N;
            else if (p.adapter)
               why = REASON_ADAPTER;
            else
               why = REASON_KEEP;
         end else begin
            if (64'(low_in_mate[0]) >= len / 64'd3)
               why = REASON_LOW_QUAL;
            else if (64'(n_in_mate[0]) * 64'd20 > len)
               why = REASON_MANY_N;
            else if (p.adapter)
               why = REASON_ADAPTER;
            else
               why = REASON_KEEP;
         end
         add[TOT_RAW_READS] = mates;
         add[TOT_RAW_BASES] = mates * len;
         add[TOT_RAW_GC] = 64'(gc_in_mate[0] + (paired_cfg ? gc_in_mate[1] : 0));
         add[TOT_RAW_Q20] = 64'(q20_in_mate[0] + (paired_cfg ? q20_in_mate[1] : 0));
         for (int k = 0; k < TOT_CLEAN_READS; k++)
            add[k + TOT_CLEAN_READS] = add[k];
         for (int k = 0; k < NUM_TOTALS; k++) begin
            if (k < TOT_CLEAN_READS || why == REASON_KEEP)
               stat_total[k] = sat_sum(stat_total[k], add[k]);
            o.totals[k] = stat_total[k][OUT_W-1:0];
         end
         o.keep = (why == REASON_KEEP);
         o.reason = why;
         read_outcomes = {read_outcomes, o};
         bases_in_read = 0;
         gc_in_mate = '{0, 0};
         q20_in_mate = '{0, 0};
         low_in_mate = '{0, 0};
         n_in_mate = '{0, 0};
      end
   endfunction

   function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
   endfunction

   // compare one result transfer against the oldest prediction
   function automatic void check_read_result();
      read_outcome_type                 want;
      logic [NUM_TOTALS-1:0][OUT_W-1:0] got;
      got = {rsp_clean_q20_total, rsp_clean_gc_total, rsp_clean_base_total,
             rsp_clean_read_total, rsp_raw_q20_total, rsp_raw_gc_total,
             rsp_raw_base_total, rsp_raw_read_total};
      reads_checked++;
      if (read_outcomes.size() == 0) begin
         note_mismatch("unrequested result", 64'd0, 64'd1);
      end else begin
         want = read_outcomes.pop_front();
         if (rsp_keep_read !== want.keep)
            note_mismatch("keep_read", 64'(want.keep), 64'(rsp_keep_read));
         if (rsp_reject_reason !== want.reason)
            note_mismatch("reject_reason", 64'(want.reason), 64'(rsp_reject_reason));
         for (int k = 0; k < NUM_TOTALS; k++)
            if (got[k] !== want.totals[k])
               note_mismatch(total_label[k], 64'(want.totals[k]), 64'(got[k]));
      end
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 50)
         return 0;
      else if (r < 88)
         return int'($urandom_range(1, 3));
      else if (r < 97)
         return int'($urandom_range(4, 10));
      return int'($urandom_range(20, 40));
   endfunction

   // stimulus helpers
   function automatic void push_position(logic [7:0] b1, logic [7:0] q1, logic [7:0] b2,
                                         logic [7:0] q2, logic last, logic adapter);
      base_position_type p;
      p.base1 = b1;
      p.qual1 = q1;
      p.base2 = b2;
      p.qual2 = q2;
      p.last = last;
      p.adapter = adapter;
      position_q = {position_q, p};
   endfunction

   // quality character a given step above the current offset
   function automatic logic [7:0] qual_at(int d);
      return 8'(int'(offset_cfg) + d);
   endfunction

   function automatic logic [7:0] random_base(int n_pct);
      int r;
      r = int'($urandom_range(0, 99));
      if (r < n_pct)
         return $urandom_range(0, 1) ? CHAR_N_UP : CHAR_N_LO;
      if (r >= 97)
         return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
         0: return CHAR_G_UP;
         1: return CHAR_C_UP;
         2: return CHAR_G_LO;
         3: return CHAR_C_LO;
         4: return "A";
         5: return "T";
         6: return "a";
         default: return "t";
      endcase
   endfunction

   function automatic logic [7:0] random_qual(int low_pct);
      int off;
      off = int'(offset_cfg);
      if ($urandom_range(0, 99) < 3)
         return 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < low_pct) begin
         if (off != 0 && $urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, off - 1));
         return 8'(off + int'($urandom_range(0, 10)));
      end
      return 8'(off + int'($urandom_range(11, 50)));
   endfunction

   // one well-formed read with random content; returns its length
   function automatic int push_random_read();
      int len;
      int sel;
      int low_pct;
      int n_pct;
      bit adapter;
      sel = int'($urandom_range(0, 99));
      if (sel < 60)
         len = int'($urandom_range(1, 4));
      else if (sel < 90)
         len = int'($urandom_range(5, 16));
      else if (sel < 98)
         len = int'($urandom_range(17, 64));
      else
         len = int'($urandom_range(65, 256));
      sel = int'($urandom_range(0, 9));
      low_pct = (sel < 4) ? 3 : (sel < 6) ? 30 : (sel < 8) ? 5 : int'($urandom_range(0, 60));
      n_pct = (sel < 4) ? 1 : (sel < 6) ? 2 : (sel < 8) ? 8 : int'($urandom_range(0, 15));
      adapter = ($urandom_range(0, 6) == 0);
      for (int i = 0; i < len; i++)
         push_position(random_base(n_pct), random_qual(low_pct), random_base(n_pct),
                       random_qual(low_pct), i == len - 1,
                       (i == len - 1) ? adapter : 1'($urandom_range(0, 1)));
      return len;
   endfunction

   // wait for the pipeline to empty, then for its latency
   task automatic drain_block();
      while (position_q.size() != 0 || req_valid || read_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [QOFS_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_QUALITY_OFFSET)
         offset_cfg = val;
      else
         paired_cfg = val[0];
   endtask

   // sender: one transfer in flight, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         send_free = !req_valid;
         if (req_valid && req_ready) begin
            score_position(offered);
            send_free = 1'b1;
            if (send_calm != 0) begin
               send_calm--;
               send_gap = 0;
            end else if ($urandom_range(0, 49) == 0) begin
               send_calm = int'($urandom_range(30, 80));
               send_gap = 0;
            end else begin
               send_gap = pick_gap();
            end
         end
         if (send_free) begin
            if (send_gap == 0 && position_q.size() != 0) begin
               offered = position_q.pop_front();
               req_base_mate1 <= offered.base1;
               req_qual_mate1 <= offered.qual1;
               req_base_mate2 <= offered.base2;
               req_qual_mate2 <= offered.qual2;
               req_last_of_read <= offered.last;
               req_adapter_listed <= offered.adapter;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
               if (send_gap != 0)
                  send_gap--;
            end
         end
      end
   end

   // receiver: check transfers, random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_read_result();
         if (recv_stall != 0) begin
            rsp_ready <= 1'b0;
            recv_stall--;
         end else if (!long_hold_done && reads_checked >= LONG_HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            recv_stall = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end else begin
            rsp_ready <= 1'b1;
            if (recv_calm != 0)
               recv_calm--;
            else if ($urandom_range(0, 49) == 0)
               recv_calm = int'($urandom_range(30, 80));
            else
               recv_stall = pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   int phase_offset [NUM_PHASES] = '{33, 64, 0, 127, 127, 0, 33, 64};
   bit phase_paired [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 0, 1};

   initial begin
      int pushed;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed reads at the reset settings: offset 33, paired
      push_position(CHAR_G_UP, qual_at(20), CHAR_C_UP, qual_at(19), 1'b1, 1'b0);
      push_position("A", 8'hFF, "T", qual_at(30), 1'b1, 1'b1);
      push_position(CHAR_G_LO, qual_at(30), CHAR_N_LO, qual_at(30), 1'b1, 1'b0);
      push_position(CHAR_C_LO, qual_at(30), "A", qual_at(10), 1'b1, 1'b0);
      // low quality outranks N and adapter; N outranks adapter
      push_position(CHAR_N_UP, 8'h00, "T", qual_at(30), 1'b1, 1'b1);
      push_position("T", qual_at(11), CHAR_N_UP, qual_at(30), 1'b1, 1'b1);
      // exactly 30 percent low on mate 1
      for (int i = 0; i < 10; i++)
         push_position((i % 2) ? CHAR_G_UP : "T", qual_at(boundary_qual[i]), CHAR_G_UP,
                       qual_at(30), i == 9, 1'b0);
      // mode switched to single part-way through a read
      for (int i = 0; i < 3; i++)
         push_position(CHAR_C_UP, qual_at(30), CHAR_G_UP, qual_at(30), 1'b0, 1'b1);
      drain_block();
      write_register(CSR_PAIRED_MODE, QOFS_W'(0));
      push_position(CHAR_G_UP, qual_at(30), CHAR_C_UP, qual_at(30), 1'b1, 1'b0);
      // single mode ignores mate 2; a two-base read always fails the low-quality rule
      for (int i = 0; i < 3; i++)
         push_position("A", qual_at(30), CHAR_N_UP, 8'h00, i == 2, 1'b0);
      for (int i = 0; i < 2; i++)
         push_position(CHAR_C_UP, qual_at(30), "A", qual_at(30), i == 1, 1'b0);
      drain_block();

      // overlong read: bases past the cap are junk and must be ignored
      write_register(CSR_PAIRED_MODE, QOFS_W'(1));
      for (int i = 0; i < READ_CAP + 6; i++) begin
         if (i < READ_CAP)
            push_position(random_base(0), random_qual(0), random_base(0), random_qual(0),
                          1'b0, 1'b0);
         else
            push_position(CHAR_N_UP, 8'h00, CHAR_N_LO, 8'h00, i == READ_CAP + 5, 1'b0);
      end
      drain_block();

      // random phases, each under its own settings, extremes included
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_register(CSR_QUALITY_OFFSET, QOFS_W'(phase_offset[ph]));
         write_register(CSR_PAIRED_MODE, QOFS_W'(phase_paired[ph]));
         pushed = 0;
         while (pushed < PHASE_POSITIONS)
            pushed += push_random_read();
         drain_block();
      end

      repeat (SETTLE_CYCLES * 4) @(posedge clock);
      if (read_outcomes.size() != 0)
         note_mismatch("results never delivered", 64'(read_outcomes.size()), 64'd0);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/frqf_pkg.sv
sv/frqf_lane.sv
sv/frqf_merge.sv
sv/fastq_read_quality_filter.sv
dv/fastq_read_quality_filter_tb.sv
